// ----- hdl/ppp_pkg.sv -----
package ppp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FOCAL_X      = 3'd0;
  localparam cfg_idx_t REG_FOCAL_Y      = 3'd1;
  localparam cfg_idx_t REG_CENTER_X     = 3'd2;
  localparam cfg_idx_t REG_CENTER_Y     = 3'd3;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd4;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd5;

  // field widths
  localparam int COORD_W   = 32;
  localparam int INTEN_W   = 16;
  localparam int PIX_W     = 13;
  localparam int DIM_REG_W = 14;
  localparam int PARAM_W   = 32;

  // stream data widths
  localparam int IN_TDATA_W  = 3 * COORD_W + INTEN_W;   // 112
  localparam int OUT_USED_W  = 2 * PIX_W + IN_TDATA_W;  // 138
  localparam int OUT_TDATA_W = 144;

  // register reset values
  localparam logic [PARAM_W-1:0]   FOCAL_X_RST      = 32'd32768000;
  localparam logic [PARAM_W-1:0]   FOCAL_Y_RST      = 32'd32768000;
  localparam logic [PARAM_W-1:0]   CENTER_X_RST     = 32'd20971520;
  localparam logic [PARAM_W-1:0]   CENTER_Y_RST     = 32'd15728640;
  localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST  = 14'd640;
  localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST = 14'd480;

  // per-axis result handed back by a lane
  typedef struct packed {
    logic             in_img;
    logic [PIX_W-1:0] pix;
  } lane_res_t;

endpackage

// ----- hdl/ppp_lane.sv -----
module ppp_lane
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 32,
  parameter int LIM_W     = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [PARAM_W-1:0]   focal,
  input  logic [PARAM_W-1:0]   center,
  input  logic [LIM_W-1:0]     lim,
  input  logic [COORD_W-1:0]   mag,
  input  logic [COORD_W-1:0]   dvs,
  input  logic                 neg,
  output lane_res_t            res
);

  localparam int PW = 2 * COORD_W;
  localparam int UW = QW + 2;

  // product stage
  logic [PW-1:0]      prod_c;
  logic [PW-1:0]      prod;
  logic [COORD_W-1:0] dvs1;
  logic               neg1;

  assign prod_c = PW'(focal) * PW'(mag);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_c;
      dvs1 <= dvs;
      neg1 <= neg;
    end
  end

  // divider stages: one quotient bit each, remainder stays below the divisor unless ov is set
  logic [COORD_W-1:0] rem [0:QW-1];
  logic [QW-1:0]      low [0:QW-1];
  logic [QW-1:0]      quo [0:QW];
  logic [COORD_W-1:0] dv  [0:QW-1];
  logic               ng  [0:QW];
  logic               ov  [0:QW];

  // quotient past QW bits always lands outside the image
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= COORD_W'(prod[PW-1:QW]);
      low[0] <= prod[QW-1:0];
      quo[0] <= '0;
      dv[0]  <= dvs1;
      ng[0]  <= neg1;
      ov[0]  <= COORD_W'(prod[PW-1:QW]) >= dvs1;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [COORD_W:0] trial;

    assign trial = {rem[k], low[k][QW-1]} - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1] <= {quo[k][QW-2:0], ~trial[COORD_W]};
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= trial[COORD_W] ? {rem[k][COORD_W-2:0], low[k][QW-1]}
                                     : trial[COORD_W-1:0];
          low[k+1] <= {low[k][QW-2:0], 1'b0};
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  // center add
  logic signed [UW-1:0] u_a;
  logic                 ov_a;

  always_ff @(posedge clk) begin
    if (en) begin
      u_a  <= ng[QW] ? $signed(UW'(center)) - $signed(UW'(quo[QW]))
                     : $signed(UW'(center)) + $signed(UW'(quo[QW]));
      ov_a <= ov[QW];
    end
  end

  // bound compare and pixel index
  logic [UW-1:0] ush;

  assign ush = $unsigned(u_a) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      res.in_img <= !ov_a && (u_a > 0) && (u_a < $signed(UW'(lim)));
      res.pix    <= ush[PIX_W-1:0];
    end
  end

endmodule

// ----- hdl/pinhole_point_projector.sv -----
// Pipeline: sign/magnitude split, product, restoring divider (one bit/stage), center add
// and bound compare, with QW = max(32, clog2(MAX_DIM+1) + FRAC_BITS).
// Throughput: one point per cycle; the whole pipe advances whenever the output
// register is empty or being taken. Dropped points leave empty slots behind.
// Reset (rst, synchronous): clears all valid bits and loads the default camera
// intrinsics (500 px focal, 320/240 center, 640x480 image).
module pinhole_point_projector
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MAX_DIM   = 8192
) (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input point stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // point_x, point_y, point_z, point_intensity
  // projected point stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // pixel_col, pixel_row, out_x, out_y, out_z,
                                           // out_intensity, zero pad
);

  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int LIM_W      = DIM_W + FRAC_BITS;
  localparam int QW         = (LIM_W > COORD_W) ? LIM_W : COORD_W;
  localparam int LAT        = QW + 4;   // lane depth
  localparam int NEAR_LIMIT = ((1 << FRAC_BITS) + 999) / 1000;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PARAM_W-1:0]   focal_x, focal_y, center_x, center_y;
  logic [DIM_REG_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= FOCAL_X_RST;
      focal_y      <= FOCAL_Y_RST;
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOCAL_X:      focal_x      <= cfg_data;
        REG_FOCAL_Y:      focal_y      <= cfg_data;
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Bounds clamped to MAX_DIM and moved to Q format. Registered: config must only
  // change while the pipe is empty; the block itself does not enforce this.
  logic [DIM_W-1:0] bnd_w, bnd_h;
  logic [LIM_W-1:0] lim_w, lim_h;

  assign bnd_w = (32'(image_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                   : DIM_W'(image_width);
  assign bnd_h = (32'(image_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                    : DIM_W'(image_height);

  always_ff @(posedge clk) begin
    lim_w <= LIM_W'(bnd_w) << FRAC_BITS;
    lim_h <= LIM_W'(bnd_h) << FRAC_BITS;
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: single enable, input ready follows the output side directly
  // ---------------------------------------------------------------------------
  logic en;

  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: sign/magnitude split and near-depth drop
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [COORD_W-1:0] mx_c, my_c, mz_c;

  assign in_x = s_tdata[COORD_W-1:0];
  assign in_y = s_tdata[2*COORD_W-1:COORD_W];
  assign in_z = s_tdata[3*COORD_W-1:2*COORD_W];

  // -2^31 maps to 2^31, which still fits unsigned
  assign mx_c = in_x[COORD_W-1] ? COORD_W'(0) - in_x : in_x;
  assign my_c = in_y[COORD_W-1] ? COORD_W'(0) - in_y : in_y;
  assign mz_c = in_z[COORD_W-1] ? COORD_W'(0) - in_z : in_z;

  logic [COORD_W-1:0] mx, my, mz;
  logic               neg_x, neg_y;

  always_ff @(posedge clk) begin
    if (en) begin
      mx    <= mx_c;
      my    <= my_c;
      mz    <= mz_c;
      neg_x <= in_x[COORD_W-1] ^ in_z[COORD_W-1];
      neg_y <= in_y[COORD_W-1] ^ in_z[COORD_W-1];
    end
  end

  // valid line: bit 0 is stage 1, bit LAT lines up with the lane outputs
  logic [LAT:0] alive;

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= '0;
    end else if (en) begin
      alive <= {alive[LAT-1:0], s_tvalid & (mz_c >= COORD_W'(NEAR_LIMIT))};
    end
  end

  // point payload rides along unchanged
  logic [IN_TDATA_W-1:0] pl [0:LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      pl[0] <= s_tdata;
      for (int k = 1; k <= LAT; k++) begin
        pl[k] <= pl[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis multiply, divide, center add and bound test
  // ---------------------------------------------------------------------------
  lane_res_t res_u, res_v;

  ppp_lane #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW),
    .LIM_W     (LIM_W)
  ) u_lane_u (
    .clk    (clk),
    .en     (en),
    .focal  (focal_x),
    .center (center_x),
    .lim    (lim_w),
    .mag    (mx),
    .dvs    (mz),
    .neg    (neg_x),
    .res    (res_u)
  );

  ppp_lane #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW),
    .LIM_W     (LIM_W)
  ) u_lane_v (
    .clk    (clk),
    .en     (en),
    .focal  (focal_y),
    .center (center_y),
    .lim    (lim_h),
    .mag    (my),
    .dvs    (mz),
    .neg    (neg_y),
    .res    (res_v)
  );

  // ---------------------------------------------------------------------------
  // Output register: last lane stage plus payload line tail
  // ---------------------------------------------------------------------------
  assign m_tvalid = alive[LAT] & res_u.in_img & res_v.in_img;
  assign m_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), pl[LAT], res_v.pix, res_u.pix};

endmodule

// ----- hdl/ppp_checker.sv -----
module ppp_checker
  import ppp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input side only stalls when a result is held back
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (m_tready || !m_tvalid))
    else $error("input ready does not follow output stall");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

  // pad bits above the payload stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind pinhole_point_projector ppp_checker u_ppp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_pinhole_point_projector.sv -----
module tb_pinhole_point_projector
  import ppp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = 16;
  localparam int MAX_DIM      = 8192;
  localparam int Q            = 1 << FRAC;     // 1.0 in Q16.16
  localparam int DRAIN_CYCLES = 48;            // outlasts the pipe depth at the defaults
  // |z| below ceil(0.001 m) in raw LSBs is dropped (66 for Q16.16)
  localparam longint unsigned NEAR_Z = ((64'd1 << FRAC) + 999) / 1000;

  typedef enum {FREE_FLOW, SRC_GAPS, SNK_STALLS, BOTH_IDLE} idle_mode_t;

  // one lidar point as it goes in
  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic [INTEN_W-1:0]        inten;
  } point_t;

  // one projected point as it comes out
  typedef struct {
    logic [PIX_W-1:0]   col, row;
    logic [COORD_W-1:0] x, y, z;
    logic [INTEN_W-1:0] inten;
  } proj_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // point_x, point_y, point_z, point_intensity
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // pixel_col, pixel_row, out_x, out_y, out_z,
                                          // out_intensity, zero pad

  // camera intrinsics as the testbench believes the block holds them
  logic [PARAM_W-1:0]   focal_x_q  = FOCAL_X_RST;
  logic [PARAM_W-1:0]   focal_y_q  = FOCAL_Y_RST;
  logic [PARAM_W-1:0]   center_x_q = CENTER_X_RST;
  logic [PARAM_W-1:0]   center_y_q = CENTER_Y_RST;
  logic [DIM_REG_W-1:0] img_w      = IMAGE_WIDTH_RST;
  logic [DIM_REG_W-1:0] img_h      = IMAGE_HEIGHT_RST;

  point_t points_to_send[$];   // waiting for an input transfer
  proj_t  projected_due[$];    // predicted outputs, oldest first
  logic   taken = 1'b0;        // the point on s_tdata went across at the last rising edge
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;
  bit     failed = 1'b0;

  pinhole_point_projector #(
    .FRAC_BITS(FRAC),
    .MAX_DIM  (MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // image bounds above MAX_DIM behave as MAX_DIM
  function automatic longint unsigned eff_dim(logic [DIM_REG_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  // Pinhole projection: exact focal*coord, quotient truncated toward zero,
  // sign from coord and depth, center added, strict bounds test in Q16.16.
  // Returns 1 when the point lands in the image.
  function automatic bit project_point(input point_t p, output proj_t r);
    longint unsigned mx, my, mz, rx, ry;
    longint          u, v;
    bit              nx, ny, nz;
    nx = p.x[31];
    ny = p.y[31];
    nz = p.z[31];
    mx = nx ? 64'h1_0000_0000 - {32'd0, p.x} : {32'd0, p.x};
    my = ny ? 64'h1_0000_0000 - {32'd0, p.y} : {32'd0, p.y};
    mz = nz ? 64'h1_0000_0000 - {32'd0, p.z} : {32'd0, p.z};
    r = '{default: '0};
    if (mz < NEAR_Z) return 1'b0;
    rx = ({32'd0, focal_x_q} * mx) / mz;
    ry = ({32'd0, focal_y_q} * my) / mz;
    u = (nx != nz) ? longint'({32'd0, center_x_q}) - longint'(rx)
                   : longint'({32'd0, center_x_q}) + longint'(rx);
    v = (ny != nz) ? longint'({32'd0, center_y_q}) - longint'(ry)
                   : longint'({32'd0, center_y_q}) + longint'(ry);
    if (!(u > 0 && u < longint'(eff_dim(img_w) << FRAC))) return 1'b0;
    if (!(v > 0 && v < longint'(eff_dim(img_h) << FRAC))) return 1'b0;
    r.col   = PIX_W'(u >> FRAC);
    r.row   = PIX_W'(v >> FRAC);
    r.x     = p.x;
    r.y     = p.y;
    r.z     = p.z;
    r.inten = p.inten;
    return 1'b1;
  endfunction

  // coordinate that puts the point near a wanted image offset, saturated to 32 bits
  function automatic logic [COORD_W-1:0] solve_coord(real offset, real depth,
                                                      logic [PARAM_W-1:0] focal);
    real c;
    if (focal == 0) return $urandom;
    c = offset * depth / real'(focal);
    if (c > 2147483647.0) c = 2147483647.0;
    if (c < -2147483648.0) c = -2147483648.0;
    return $rtoi(c);
  endfunction

  // Mostly points aimed at a band a bit wider than the image, so both the
  // inside and the edges get hit; some near-zero depths, some pure noise.
  function automatic point_t make_point();
    point_t p;
    real    zr, ur, vr;
    int     zsel;
    p.inten = INTEN_W'($urandom);
    if ($urandom_range(99) < 15) begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
      return p;
    end
    zsel = $urandom_range(99);
    if (zsel < 25)      p.z = $urandom_range(4000, 40);
    else if (zsel < 85) p.z = $urandom_range(100 * Q, Q / 2);
    else                p.z = $urandom_range(32'h7FFF_FFFF, 66);
    if ($urandom_range(99) < 20) p.z = -p.z;
    zr = real'(p.z);
    ur = ($urandom_range(1200) / 1000.0 - 0.1) * real'(eff_dim(img_w)) * Q;
    vr = ($urandom_range(1200) / 1000.0 - 0.1) * real'(eff_dim(img_h)) * Q;
    p.x = solve_coord(ur - real'(center_x_q), zr, focal_x_q);
    p.y = solve_coord(vr - real'(center_y_q), zr, focal_y_q);
    return p;
  endfunction

  task automatic enqueue_point(int x, int y, int z, int inten);
    point_t p;
    p.x     = x;
    p.y     = y;
    p.z     = z;
    p.inten = INTEN_W'(inten);
    points_to_send.insert(points_to_send.size(), p);
  endtask

  // one register write per falling edge; the enable drops after the last one
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FOCAL_X:      focal_x_q  = val;
      REG_FOCAL_Y:      focal_y_q  = val;
      REG_CENTER_X:     center_x_q = val;
      REG_CENTER_Y:     center_y_q = val;
      REG_IMAGE_WIDTH:  img_w      = val[DIM_REG_W-1:0];
      REG_IMAGE_HEIGHT: img_h      = val[DIM_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] fx, fy, cx, cy, input logic [13:0] w, h);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every point went in and every projection came out, then let
  // dropped points still in the pipe run out before touching registers.
  task automatic drain();
    while (points_to_send.size() != 0 || projected_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(idle_mode_t mode, input logic [31:0] fx, fy, cx, cy,
                           input logic [13:0] w, h, input int n, input int min_hits);
    point_t p;
    proj_t  r;
    int     count;
    int     hits;
    drain();
    case (mode)
      FREE_FLOW:  begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      SRC_GAPS:   begin src_idle_pct = 70; snk_stall_pct = 0;  end
      SNK_STALLS: begin src_idle_pct = 0;  snk_stall_pct = 70; end
      BOTH_IDLE:  begin src_idle_pct = 31; snk_stall_pct = 31; end
      default: ;
    endcase
    configure(fx, fy, cx, cy, w, h);
    count = 0;
    hits  = 0;
    // keep going past n when projections are scarce, within reason
    while ((count < n || hits < min_hits) && count < 4 * n) begin
      p = make_point();
      if (project_point(p, r)) hits++;
      points_to_send.insert(points_to_send.size(), p);
      count++;
    end
  endtask

  // Source side: a new point goes on the bus only after the previous one was
  // taken; random gaps according to the current phase.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || taken)) begin
      if (points_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {points_to_send[0].inten, points_to_send[0].z,
                     points_to_send[0].y, points_to_send[0].x};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // input transfer: predict, retire the point from the send queue
  always @(posedge clk) begin : accept_point
    proj_t res;
    if (!rst && s_tvalid && s_tready) begin
      if (project_point(points_to_send[0], res)) begin
        projected_due.insert(projected_due.size(), res);
      end
      points_to_send.delete(0);
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  // sink side backpressure
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // output transfer: compare against the oldest prediction
  always @(posedge clk) begin : check_projection
    proj_t got;
    proj_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.col   = m_tdata[12:0];
      got.row   = m_tdata[25:13];
      got.x     = m_tdata[57:26];
      got.y     = m_tdata[89:58];
      got.z     = m_tdata[121:90];
      got.inten = m_tdata[137:122];
      if (projected_due.size() == 0) begin
        $error("projected point with none predicted: col %0d row %0d", got.col, got.row);
        failed = 1'b1;
      end else begin
        want = projected_due[0];
        projected_due.delete(0);
        check_field("pixel_col", 64'(want.col), 64'(got.col));
        check_field("pixel_row", 64'(want.row), 64'(got.row));
        check_field("out_x", 64'(want.x), 64'(got.x));
        check_field("out_y", 64'(want.y), 64'(got.y));
        check_field("out_z", 64'(want.z), 64'(got.z));
        check_field("out_intensity", 64'(want.inten), 64'(got.inten));
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed points against the reset intrinsics (500 px focal, 320/240
    // center, 640x480). With z = 500.0 the ratio focal*x/z is x exactly,
    // which lets the strict image edges be hit to the LSB.
    enqueue_point(0, 0, Q, 0);                      // on axis
    enqueue_point(0, 0, -Q, 16'hFFFF);              // behind camera, on axis
    enqueue_point(Q / 10, Q / 20, -Q, 1234);        // behind camera, mirrored
    enqueue_point(0, 0, 65, 1);                     // depth just under near limit
    enqueue_point(0, 0, -65, 2);
    enqueue_point(0, 0, 66, 3);                     // depth right at near limit
    enqueue_point(0, 0, -66, 4);
    enqueue_point(0, 0, 0, 5);                      // zero depth
    enqueue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 6);
    enqueue_point(32'h8000_0000, 0, 32'h8000_0000, 7);
    enqueue_point(32'h8000_0000, 32'h7FFF_FFFF, Q, 8);
    enqueue_point(-20971520, 0, 32768000, 9);       // u exactly 0
    enqueue_point(-20971519, 0, 32768000, 10);      // first LSB inside
    enqueue_point(20971520, 0, 32768000, 11);       // u exactly at width
    enqueue_point(20971519, 0, 32768000, 12);       // last LSB inside
    enqueue_point(0, -15728640, 32768000, 13);      // v exactly 0
    enqueue_point(0, -15728639, 32768000, 14);
    enqueue_point(0, 15728640, 32768000, 15);       // v exactly at height
    enqueue_point(0, 15728639, 32768000, 16);
    enqueue_point(-1, -1, Q, 16'hFFFF);
    enqueue_point(1, 1, 66, 16'h8000);

    // defaults again, then both extremes of every register
    run_phase(FREE_FLOW, 32768000, 32768000, 20971520, 15728640, 14'd640, 14'd480,
              250, 40);
    run_phase(SRC_GAPS, 1, 1, 0, 0, 14'd1, 14'd1, 200, 40);
    // bounds above MAX_DIM, center far right and below the image
    run_phase(SNK_STALLS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              14'h3FFF, 14'h3FFF, 220, 40);
    // zero width: nothing may come out
    run_phase(BOTH_IDLE, 32768000, 32768000, 20971520, 15728640, 14'd0, 14'd8192, 80, 0);
    // zero horizontal focal length: u sits at the center
    run_phase(FREE_FLOW, 0, 300 * Q, 6586368, 50 * Q, 14'd200, 14'd100, 150, 40);

    // random camera setups
    for (int i = 0; i < 3; i++) begin
      logic [13:0] w, h;
      w = 14'($urandom_range(16383, 1));
      h = 14'($urandom_range(16383, 1));
      run_phase(idle_mode_t'(i + 1), $urandom_range(2000 * Q, 50 * Q),
                $urandom_range(2000 * Q, 50 * Q),
                $urandom_range(32'(eff_dim(w) * Q)), $urandom_range(32'(eff_dim(h) * Q)),
                w, h, 230, 40);
    end

    drain();
    if (!failed) begin
      $display("tb_pinhole_point_projector passed");
    end else begin
      $display("tb_pinhole_point_projector failed");
    end
    $finish;
  end

  // hung handshake guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_pinhole_point_projector failed");
    $finish;
  end

endmodule
